// ----- rtl/core/sfdm_pkg.sv -----
// Shared types and constants for the signed floored divider.
// No dependencies; imported by every module under rtl/core.
`timescale 1ns / 1ps

package sfdm_pkg;

	localparam int DATA_WIDTH = 16;
	localparam int OUT_WIDTH  = DATA_WIDTH + 1;

	// Word handed from cell to cell along the divider chain.
	typedef struct packed {
		logic [DATA_WIDTH-1:0] rem;   // partial remainder
		logic [DATA_WIDTH-1:0] qa;    // dividend bits shifting out, quotient bits shifting in
		logic [DATA_WIDTH-1:0] dvs;   // divisor magnitude
		logic                  neg;   // effective dividend is negative
		logic                  zdiv;  // divisor was zero
		logic [DATA_WIDTH-1:0] dvd;   // raw dividend, for the zero divisor case
	} sfdm_word_t;

endpackage

// ----- rtl/core/signed_floor_divmod_top.sv -----
// Throughput: one word per cycle while no rsp_stall backs up the chain; the chain is one
// sign stage, one restoring cell per quotient bit, and the floor-correction output
// register.
// Stages fill bubbles independently, so input keeps flowing while a result waits, until the chain is full.
// Reset: arst_n clears all valid flags asynchronously; no clearing pass.
// Depends on sfdm_pkg, sfdm_prep, sfdm_cell, sfdm_fix.
`timescale 1ns / 1ps

module signed_floor_divmod_top import sfdm_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_stall,
	input  logic [DATA_WIDTH-1:0] dividend,
	input  logic [DATA_WIDTH-1:0] divisor,
	output logic                 rsp_valid,
	input  logic                 rsp_stall,
	output logic [OUT_WIDTH-1:0] quotient,
	output logic [OUT_WIDTH-1:0] remainder,
	output logic                 zero_divisor
);

	logic       chain_valid [DATA_WIDTH+1];
	logic       chain_ready [DATA_WIDTH+1];
	sfdm_word_t chain_word  [DATA_WIDTH+1];
	logic       prep_ready;

	assign req_stall = !prep_ready;

	sfdm_prep u_prep (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req_valid),
		.in_ready  (prep_ready),
		.dividend  (dividend),
		.divisor   (divisor),
		.out_valid (chain_valid[0]),
		.out_ready (chain_ready[0]),
		.out_word  (chain_word[0])
	);

	for (genvar i = 0; i < DATA_WIDTH; i++) begin : g_cell
		sfdm_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (chain_valid[i]),
			.in_ready  (chain_ready[i]),
			.in_word   (chain_word[i]),
			.out_valid (chain_valid[i+1]),
			.out_ready (chain_ready[i+1]),
			.out_word  (chain_word[i+1])
		);
	end

	sfdm_fix u_fix (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (chain_valid[DATA_WIDTH]),
		.in_ready     (chain_ready[DATA_WIDTH]),
		.in_word      (chain_word[DATA_WIDTH]),
		.out_valid    (rsp_valid),
		.out_stall    (rsp_stall),
		.quotient     (quotient),
		.remainder    (remainder),
		.zero_divisor (zero_divisor)
	);

endmodule

// ----- rtl/core/sfdm_prep.sv -----
// Sign handling stage: magnitudes, sign of the result, zero divisor detect.
// Depends on sfdm_pkg.
`timescale 1ns / 1ps

module sfdm_prep import sfdm_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [DATA_WIDTH-1:0] dividend,
	input  logic [DATA_WIDTH-1:0] divisor,
	output logic                  out_valid,
	input  logic                  out_ready,
	output sfdm_word_t            out_word
);

	logic       valid_q;
	sfdm_word_t word_q;
	sfdm_word_t word_d;
	logic       a_neg;
	logic       b_neg;

	assign a_neg = dividend[DATA_WIDTH-1];
	assign b_neg = divisor[DATA_WIDTH-1];

	always_comb begin
		word_d      = '0;
		// magnitude of the most negative value fits unsigned
		word_d.rem  = '0;
		word_d.qa   = a_neg ? (~dividend + 1'b1) : dividend;
		word_d.dvs  = b_neg ? (~divisor + 1'b1) : divisor;
		word_d.neg  = a_neg ^ b_neg;
		word_d.zdiv = (divisor == '0);
		word_d.dvd  = dividend;
	end

	assign in_ready  = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_word  = word_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			word_q <= word_d;
		end
	end

endmodule

// ----- rtl/core/sfdm_cell.sv -----
// One restoring division step: shifts in a dividend bit, subtracts if it fits.
// Depends on sfdm_pkg.
`timescale 1ns / 1ps

module sfdm_cell import sfdm_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  sfdm_word_t in_word,
	output logic       out_valid,
	input  logic       out_ready,
	output sfdm_word_t out_word
);

	logic                  valid_q;
	sfdm_word_t            word_q;
	sfdm_word_t            word_d;
	logic [DATA_WIDTH-1:0] trial;
	logic                  fits;

	// for a nonzero divisor the partial remainder stays below it, so its top bit is always clear
	assign trial = {in_word.rem[DATA_WIDTH-2:0], in_word.qa[DATA_WIDTH-1]};
	assign fits  = (trial >= in_word.dvs);

	always_comb begin
		word_d     = in_word;
		word_d.rem = fits ? (trial - in_word.dvs) : trial;
		word_d.qa  = {in_word.qa[DATA_WIDTH-2:0], fits};
	end

	assign in_ready  = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_word  = word_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			word_q <= word_d;
		end
	end

endmodule

// ----- rtl/core/sfdm_fix.sv -----
// Floor correction of the unsigned quotient and remainder, and the output register.
// Depends on sfdm_pkg.
`timescale 1ns / 1ps

module sfdm_fix import sfdm_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  sfdm_word_t           in_word,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [OUT_WIDTH-1:0] quotient,
	output logic [OUT_WIDTH-1:0] remainder,
	output logic                 zero_divisor
);

	logic                 valid_q;
	logic [OUT_WIDTH-1:0] quo_q;
	logic [OUT_WIDTH-1:0] rem_q;
	logic                 zdiv_q;
	logic [OUT_WIDTH-1:0] quo_d;
	logic [OUT_WIDTH-1:0] rem_d;
	logic [OUT_WIDTH-1:0] q_mag;
	logic [OUT_WIDTH-1:0] r_mag;

	assign q_mag = {1'b0, in_word.qa};
	assign r_mag = {1'b0, in_word.rem};

	always_comb begin
		priority if (in_word.zdiv) begin
			quo_d = '0;
			rem_d = {in_word.dvd[DATA_WIDTH-1], in_word.dvd};
		end else if (!in_word.neg) begin
			quo_d = q_mag;
			rem_d = r_mag;
		end else if (in_word.rem == '0) begin
			quo_d = ~q_mag + 1'b1;
			rem_d = '0;
		end else begin
			// floor of a negative fraction: -Q-1, remainder folds to B-R
			quo_d = ~q_mag;
			rem_d = {1'b0, in_word.dvs - in_word.rem};
		end
	end

	assign in_ready     = !valid_q || !out_stall;
	assign out_valid    = valid_q;
	assign quotient     = quo_q;
	assign remainder    = rem_q;
	assign zero_divisor = zdiv_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			quo_q  <= quo_d;
			rem_q  <= rem_d;
			zdiv_q <= in_word.zdiv;
		end
	end

`ifndef SYNTHESIS
	a_rem_below_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_word.zdiv |-> in_word.rem < in_word.dvs)
		else $error("partial remainder not below divisor");

	a_zero_quotient: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && zdiv_q |-> quo_q == '0)
		else $error("zero divisor word with nonzero quotient");

	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && !zdiv_q |-> rem_q[OUT_WIDTH-1:OUT_WIDTH-2] == 2'b00)
		else $error("remainder out of range");

	a_load_valid: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> valid_q)
		else $error("accepted word lost at output register");
`endif

endmodule

// ----- bench/signed_floor_divmod_top_tb.sv -----
// Self-checking bench for signed_floor_divmod_top: directed corner words, then random
// words under four idle/stall mixes, each result checked against an in-bench predictor.
// Depends on sfdm_pkg and the RTL under rtl/core.
`timescale 1ns / 1ps

module signed_floor_divmod_top_tb;
	import sfdm_pkg::*;

	localparam int PIPE_LATENCY = DATA_WIDTH + 2;
	localparam int CYCLE_LIMIT  = 400000;

	typedef struct {
		logic [OUT_WIDTH-1:0] quo;
		logic [OUT_WIDTH-1:0] rem;
		logic                 zdiv;
	} divmod_result_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  req_valid = 1'b0;
	logic                  req_stall;
	logic [DATA_WIDTH-1:0] dividend = '0;
	logic [DATA_WIDTH-1:0] divisor = '0;
	logic                  rsp_valid;
	logic                  rsp_stall = 1'b0;
	logic [OUT_WIDTH-1:0]  quotient;
	logic [OUT_WIDTH-1:0]  remainder;
	logic                  zero_divisor;

	divmod_result_t pending_results[$];
	int idle_pct = 0;
	int stall_pct = 0;
	int words_sent = 0;
	int results_checked = 0;
	int zero_div_seen = 0;
	int mismatch_count = 0;
	int cycle_count = 0;

	signed_floor_divmod_top u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (req_valid),
		.req_stall    (req_stall),
		.dividend     (dividend),
		.divisor      (divisor),
		.rsp_valid    (rsp_valid),
		.rsp_stall    (rsp_stall),
		.quotient     (quotient),
		.remainder    (remainder),
		.zero_divisor (zero_divisor)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Floored divide; a negative divisor flips both operands first.
	function automatic divmod_result_t floor_divmod(logic [DATA_WIDTH-1:0] a_raw,
			logic [DATA_WIDTH-1:0] b_raw);
		longint a, b, q, r;
		divmod_result_t res;
		a = longint'(signed'(a_raw));
		b = longint'(signed'(b_raw));
		if (b == 0) begin
			res.quo  = '0;
			res.rem  = OUT_WIDTH'(a);
			res.zdiv = 1'b1;
			return res;
		end
		if (b < 0) begin
			a = -a;
			b = -b;
		end
		q = a / b;
		r = a - q * b;
		if (r < 0) begin
			q = q - 1;
			r = r + b;
		end
		res.quo  = OUT_WIDTH'(q);
		res.rem  = OUT_WIDTH'(r);
		res.zdiv = 1'b0;
		return res;
	endfunction

	function automatic logic [DATA_WIDTH-1:0] rand_operand();
		int sel;
		sel = $urandom_range(7);
		case (sel)
			0: begin
				return DATA_WIDTH'($urandom_range(31)) - DATA_WIDTH'(16);
			end
			1: begin
				case ($urandom_range(4))
					0: return {1'b1, {(DATA_WIDTH-1){1'b0}}};
					1: return {1'b0, {(DATA_WIDTH-1){1'b1}}};
					2: return '1;
					3: return DATA_WIDTH'(1);
					default: return '0;
				endcase
			end
			2: begin
				// powers of two and their neighbors
				return (DATA_WIDTH'(1) << $urandom_range(DATA_WIDTH-1))
					+ DATA_WIDTH'($urandom_range(2)) - DATA_WIDTH'(1);
			end
			3: begin
				return -(DATA_WIDTH'(1) << $urandom_range(DATA_WIDTH-1));
			end
			default: begin
				return DATA_WIDTH'($urandom);
			end
		endcase
	endfunction

	task automatic report_mismatch(string what, logic [OUT_WIDTH-1:0] got,
			logic [OUT_WIDTH-1:0] want);
		mismatch_count++;
		$display("MISMATCH @%0t %s: got %h want %h", $realtime, what, got, want);
	endtask

	// Valid stays high across back-to-back words; it drops only for an idle gap.
	task automatic send_word(logic [DATA_WIDTH-1:0] a, logic [DATA_WIDTH-1:0] b);
		if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
			req_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < idle_pct);
		end
		req_valid <= 1'b1;
		dividend  <= a;
		divisor   <= b;
		do @(posedge clk); while (req_stall);
		pending_results.push_back(floor_divmod(a, b));
		words_sent++;
	endtask

	task automatic go_idle();
		req_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic drain();
		int hold = 0;
		go_idle();
		stall_pct = 0;
		while (pending_results.size() != 0) @(posedge clk);
		// catch any stray extra result
		while (hold < 2 * PIPE_LATENCY) begin
			@(posedge clk);
			hold++;
		end
	endtask

	task automatic test_directed();
		int dir_a[25] = '{0, 0, 7, -7, 7, -7, 32767, -32768, -32768, 32767,
			-32768, 32767, -32768, 32767, 5, -32768, 32767, 0, 1, -1,
			-1, 1, 100, -100, 12345};
		int dir_b[25] = '{1, -1, 2, 2, -2, -2, 1, 1, -1, -1,
			32767, -32768, -32768, 32767, 0, 0, 0, 0, 32767, 32767,
			-32768, -32768, 7, 7, -3};
		idle_pct  = 0;
		stall_pct = 0;
		foreach (dir_a[i])
			send_word(DATA_WIDTH'(dir_a[i]), DATA_WIDTH'(dir_b[i]));
		drain();
	endtask

	// Every 50 words a 10-word burst runs with no idling on either side.
	task automatic test_random(int count, int idle_mix, int stall_mix);
		for (int i = 0; i < count; i++) begin
			if (i % 50 < 10) begin
				idle_pct  = 0;
				stall_pct = 0;
			end else begin
				idle_pct  = idle_mix;
				stall_pct = stall_mix;
			end
			send_word(rand_operand(), rand_operand());
		end
		drain();
	endtask

	always @(posedge clk) begin
		if (stall_pct > 0)
			rsp_stall <= ($urandom_range(99) < stall_pct);
		else
			rsp_stall <= 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	always @(posedge clk) begin
		divmod_result_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected result word", quotient, 'x);
			end else begin
				want = pending_results.pop_front();
				results_checked++;
				if (zero_divisor)
					zero_div_seen++;
				if (quotient !== want.quo)
					report_mismatch("quotient", quotient, want.quo);
				if (remainder !== want.rem)
					report_mismatch("remainder", remainder, want.rem);
				if (zero_divisor !== want.zdiv)
					report_mismatch("zero_divisor", zero_divisor, want.zdiv);
			end
		end
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random(160, 0, 0);
		test_random(155, 72, 0);
		test_random(155, 0, 72);
		test_random(155, 38, 38);

		$display("Ran %0d words (directed corners, then random under four idle/stall mixes).",
			words_sent);
		$display("Checked %0d results, %0d with zero divisor, %0d mismatches.",
			results_checked, zero_div_seen, mismatch_count);
		if (mismatch_count == 0 && pending_results.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
